/* sv/nst_pkg.sv */
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types and constants for the NMEA sentence tokenizer and checker.
// ----------------------------------------------------------------------------
package nst_pkg;

	localparam logic [7:0] MAX_CHARS      = 8'd128;
	localparam logic [5:0] MAX_TERM_COUNT = 6'd32;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_UPPER_A = 8'd65;

	localparam logic [7:0] TAG_LEN = 8'd7;

	localparam logic [2:0] KIND_IGNORED = 3'd0;
	localparam logic [2:0] KIND_START   = 3'd1;
	localparam logic [2:0] KIND_DATA    = 3'd2;
	localparam logic [2:0] KIND_DELIM   = 3'd3;
	localparam logic [2:0] KIND_CHKSUM  = 3'd4;

	localparam logic [2:0] TAG_FULL = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_CK1  = 2'd2,
		PH_CK2  = 2'd3
	} phase_t;

	// expected characters of "$GPRMC," by sentence position
	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h24;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			3'd6: ch = 8'h2C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// unchecked hex digit value, two's complement in 14 bits
	function automatic logic [13:0] hex_value(input logic [7:0] ch);
		logic [13:0] v;
		if (ch >= CH_UPPER_A) begin
			v = {6'd0, ch} - 14'd55;
		end else begin
			v = {6'd0, ch} - 14'd48;
		end
		return v;
	endfunction

endpackage

/* sv/nst_if.sv */
// ----------------------------------------------------------------------------
// nst_if
// Valid/ready channels for received bytes and for per-byte token results.
// ----------------------------------------------------------------------------
interface nst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface nst_tok_if;
	logic       valid;
	logic       ready;
	logic [7:0] echo_char;
	logic [7:0] char_position;
	logic [2:0] char_kind;
	logic [5:0] term_number;
	logic       checksum_done;
	logic       checksum_good;
	logic       sentence_accepted;

	modport source (
		output valid, output echo_char, output char_position, output char_kind,
		output term_number, output checksum_done, output checksum_good,
		output sentence_accepted, input ready
	);
	modport sink (
		input valid, input echo_char, input char_position, input char_kind,
		input term_number, input checksum_done, input checksum_good,
		input sentence_accepted, output ready
	);
endinterface

/* sv/nmea_sentence_tokenizer_checker.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_tokenizer_checker
// Splits an NMEA 0183 byte stream into terms and checks the sentence checksum.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one received ASCII byte per beat; dout returns exactly one
//   token result per input byte, in order: the stored character, its
//   position in the sentence, its kind, the term count, and on the second
//   checksum digit the done/good flags plus the GPRMC accept flag.
//   A byte accepted from din sits in the input register, and its result is
//   registered into the result register when it moves on.
//   Throughput is one byte per cycle while dout is not stalled; the parser
//   state (phase, parity, tag match count, term and char counters) updates
//   when a byte moves from the input register to the result register.
//   Reset clears the parser to idle with all counts and parity at zero and
//   empties both registers.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps one more byte; din.ready drops only when both are
//   full and dout.ready is low.
// ----------------------------------------------------------------------------
module nmea_sentence_tokenizer_checker (
	input  logic          clk,
	input  logic          arst_n,
	nst_byte_if.sink      din,
	nst_tok_if.source     dout
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_s2;
	logic       advance;
	logic       fire;

	nst_pkg::phase_t phase_q, phase_nxt;
	logic [13:0]     parity_q, parity_nxt;
	logic [2:0]      tag_q, tag_nxt;
	logic [5:0]      term_q, term_nxt;
	logic [7:0]      char_q, char_nxt;

	logic [7:0]  echo_c, pos_c;
	logic [2:0]  kind_c;
	logic        done_c, good_c, acc_c;
	logic [13:0] hex_c;
	logic [13:0] parity_ck2;

	logic [7:0] echo_s2, pos_s2;
	logic [2:0] kind_s2;
	logic [5:0] term_s2;
	logic       done_s2, good_s2, acc_s2;

	assign advance  = !out_valid_s2 || dout.ready;
	assign fire     = valid_s1 && advance;
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= nst_pkg::PH_IDLE;
			parity_q <= '0;
			tag_q    <= '0;
			term_q   <= '0;
			char_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_nxt;
			parity_q <= parity_nxt;
			tag_q    <= tag_nxt;
			term_q   <= term_nxt;
			char_q   <= char_nxt;
		end
	end

	always_comb begin
		nst_pkg::phase_t ph;
		ph = phase_q;
		if (char_q >= nst_pkg::MAX_CHARS || term_q >= nst_pkg::MAX_TERM_COUNT) begin
			ph = nst_pkg::PH_IDLE;
		end
		if (byte_s1 == nst_pkg::CH_LF || byte_s1 == nst_pkg::CH_CR) begin
			ph = nst_pkg::PH_IDLE;
		end

		phase_nxt  = ph;
		parity_nxt = parity_q;
		tag_nxt    = tag_q;
		term_nxt   = term_q;
		char_nxt   = char_q;
		echo_c     = '0;
		pos_c      = '0;
		kind_c     = nst_pkg::KIND_IGNORED;
		done_c     = 1'b0;
		good_c     = 1'b0;
		acc_c      = 1'b0;
		hex_c      = nst_pkg::hex_value(byte_s1);
		parity_ck2 = parity_q - hex_c;

		if (byte_s1 == nst_pkg::CH_DOLLAR) begin
			tag_nxt    = '0;
			parity_nxt = '0;
			term_nxt   = '0;
			char_nxt   = 8'd1;
			phase_nxt  = nst_pkg::PH_BODY;
			echo_c     = byte_s1;
			kind_c     = nst_pkg::KIND_START;
		end else begin
			case (ph)
				nst_pkg::PH_BODY: begin
					if (char_q < nst_pkg::TAG_LEN
							&& byte_s1 == nst_pkg::tag_char(char_q[2:0])) begin
						tag_nxt = tag_q + 3'd1;
					end
					pos_c    = char_q;
					char_nxt = char_q + 8'd1;
					if (byte_s1 == nst_pkg::CH_COMMA) begin
						kind_c     = nst_pkg::KIND_DELIM;
						term_nxt   = term_q + 6'd1;
						parity_nxt = parity_q ^ {6'd0, byte_s1};
					end else if (byte_s1 == nst_pkg::CH_STAR) begin
						kind_c    = nst_pkg::KIND_DELIM;
						phase_nxt = nst_pkg::PH_CK1;
					end else begin
						echo_c     = byte_s1;
						kind_c     = nst_pkg::KIND_DATA;
						parity_nxt = parity_q ^ {6'd0, byte_s1};
					end
				end
				nst_pkg::PH_CK1: begin
					term_nxt   = term_q + 6'd1;
					echo_c     = byte_s1;
					pos_c      = char_q;
					kind_c     = nst_pkg::KIND_CHKSUM;
					char_nxt   = char_q + 8'd1;
					// high nibble weighs sixteen
					parity_nxt = parity_q - {hex_c[9:0], 4'd0};
					phase_nxt  = nst_pkg::PH_CK2;
				end
				nst_pkg::PH_CK2: begin
					echo_c     = byte_s1;
					pos_c      = char_q;
					kind_c     = nst_pkg::KIND_CHKSUM;
					char_nxt   = char_q + 8'd2;
					phase_nxt  = nst_pkg::PH_IDLE;
					parity_nxt = parity_ck2;
					done_c     = 1'b1;
					good_c     = (parity_ck2 == '0);
					acc_c      = good_c && (tag_q == nst_pkg::TAG_FULL);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			echo_s2 <= echo_c;
			pos_s2  <= pos_c;
			kind_s2 <= kind_c;
			term_s2 <= term_nxt;
			done_s2 <= done_c;
			good_s2 <= good_c;
			acc_s2  <= acc_c;
		end
	end

	assign dout.valid             = out_valid_s2;
	assign dout.echo_char         = echo_s2;
	assign dout.char_position     = pos_s2;
	assign dout.char_kind         = kind_s2;
	assign dout.term_number       = term_s2;
	assign dout.checksum_done     = done_s2;
	assign dout.checksum_good     = good_s2;
	assign dout.sentence_accepted = acc_s2;

endmodule

/* sv/nst_checker.sv */
// ----------------------------------------------------------------------------
// nst_checker
// Port-level checks on the token result channel of the sentence checker.
// ----------------------------------------------------------------------------
module nst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] echo_char,
	input logic [2:0] char_kind,
	input logic       checksum_done,
	input logic       checksum_good,
	input logic       sentence_accepted
);

	// accept implies a good checksum
	a_acc_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sentence_accepted |-> checksum_good)
		else $error("sentence accepted without good checksum");

	// good only on the beat that completes the checksum
	a_good_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_good |-> checksum_done)
		else $error("checksum good without checksum done");

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_done |-> char_kind == nst_pkg::KIND_CHKSUM)
		else $error("checksum done on a non-checksum beat");

	// ignored beats echo nothing
	a_ign_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_kind == nst_pkg::KIND_IGNORED |-> echo_char == 8'd0)
		else $error("ignored beat carries a character");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(echo_char)
			&& $stable(char_kind) && $stable(checksum_done))
		else $error("stalled result beat changed");

endmodule

bind nmea_sentence_tokenizer_checker nst_checker u_nst_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (dout.valid),
	.out_ready         (dout.ready),
	.echo_char         (dout.echo_char),
	.char_kind         (dout.char_kind),
	.checksum_done     (dout.checksum_done),
	.checksum_good     (dout.checksum_good),
	.sentence_accepted (dout.sentence_accepted)
);
